[hdl/cda_pkg.sv]
// ----------------------------------------------------------------------------
// cda_pkg
// Shared types, codes and calendar helpers for the calendar date-time adder.
// ----------------------------------------------------------------------------
package cda_pkg;

  localparam int YearWidthDefault = 16;

  localparam logic [16:0] SecsPerDay   = 17'd86400;
  localparam logic [11:0] SecsPerHour  = 12'd3600;
  localparam logic [5:0]  SecsPerMin   = 6'd60;
  localparam logic [17:0] DaysPerCycle = 18'd146097;
  localparam logic [8:0]  YearsPerCycle = 9'd400;
  localparam logic [13:0] MaxLoadYear  = 14'd9999;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_ADD_SEC = 3'd1,
    OP_SUB_SEC = 3'd2,
    OP_ADD_DAY = 3'd3,
    OP_SUB_DAY = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_LOAD,
    ST_TOD,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_FIX,
    ST_DOY,
    ST_DAYS,
    ST_MONTH,
    ST_HOUR,
    ST_MIN,
    ST_PACK_INIT,
    ST_PACK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic tod_init;
    logic div_init;
    logic div_step;
    logic div_fix;
    logic doy_step;
    logic days_step;
    logic month_step;
    logic hour_step;
    logic min_step;
    logic pack_init;
    logic pack_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       div_last;
    logic       doy_done;
    logic       days_done;
    logic       month_done;
    logic       hour_done;
    logic       min_done;
    logic       pack_last;
  } sts_t;

  // Leap rule on the year modulo 400.
  function automatic logic leap_of(logic [8:0] ymod);
    return (ymod[1:0] == 2'd0) && (ymod != 9'd100) && (ymod != 9'd200) && (ymod != 9'd300);
  endfunction

  function automatic logic [4:0] month_len(logic leap, logic [3:0] m);
    logic [4:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

[hdl/cda_if.sv]
// ----------------------------------------------------------------------------
// cda_in_if / cda_out_if
// Valid/ready channels for command items and date-time results.
// ----------------------------------------------------------------------------
interface cda_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [30:0] amount;
  logic [13:0] load_year;
  logic [6:0]  load_month;
  logic [6:0]  load_day;
  logic [6:0]  load_hour;
  logic [6:0]  load_minute;
  logic [6:0]  load_second;

  modport source(output valid, operation, amount, load_year, load_month, load_day,
                 load_hour, load_minute, load_second, input ready);
  modport sink(input valid, operation, amount, load_year, load_month, load_day,
               load_hour, load_minute, load_second, output ready);
endinterface

interface cda_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [49:0] packed_decimal;
  logic        status;
  logic        year_wrapped;

  modport source(output valid, year, month, day, hour, minute, second, packed_decimal,
                 status, year_wrapped, input ready);
  modport sink(input valid, year, month, day, hour, minute, second, packed_decimal,
               status, year_wrapped, output ready);
endinterface

[hdl/cda_ctrl.sv]
// ----------------------------------------------------------------------------
// cda_ctrl
// Sequencer: walks one item through the datapath phases.
// ----------------------------------------------------------------------------
module cda_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output cda_pkg::cmd_t  cmd,
  input  cda_pkg::sts_t  sts
);

  cda_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cda_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      cda_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = cda_pkg::ST_START;
        end
      end
      cda_pkg::ST_START: begin
        if (sts.op == cda_pkg::OP_LOAD) begin
          state_nxt = cda_pkg::ST_LOAD;
        end else if (sts.op inside {cda_pkg::OP_ADD_SEC, cda_pkg::OP_SUB_SEC,
                                    cda_pkg::OP_ADD_DAY, cda_pkg::OP_SUB_DAY}) begin
          state_nxt = cda_pkg::ST_TOD;
        end else begin
          state_nxt = cda_pkg::ST_PACK_INIT;
        end
      end
      cda_pkg::ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = cda_pkg::ST_PACK_INIT;
      end
      cda_pkg::ST_TOD: begin
        cmd.tod_init = 1'b1;
        if (sts.op inside {cda_pkg::OP_ADD_SEC, cda_pkg::OP_SUB_SEC}) begin
          state_nxt = cda_pkg::ST_DIV_INIT;
        end else begin
          state_nxt = cda_pkg::ST_DOY;
        end
      end
      cda_pkg::ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = cda_pkg::ST_DIV;
      end
      cda_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = cda_pkg::ST_DIV_FIX;
        end
      end
      cda_pkg::ST_DIV_FIX: begin
        cmd.div_fix = 1'b1;
        state_nxt   = cda_pkg::ST_DOY;
      end
      cda_pkg::ST_DOY: begin
        cmd.doy_step = 1'b1;
        if (sts.doy_done) begin
          state_nxt = cda_pkg::ST_DAYS;
        end
      end
      cda_pkg::ST_DAYS: begin
        cmd.days_step = 1'b1;
        if (sts.days_done) begin
          state_nxt = cda_pkg::ST_MONTH;
        end
      end
      cda_pkg::ST_MONTH: begin
        cmd.month_step = 1'b1;
        if (sts.month_done) begin
          state_nxt = cda_pkg::ST_HOUR;
        end
      end
      cda_pkg::ST_HOUR: begin
        cmd.hour_step = 1'b1;
        if (sts.hour_done) begin
          state_nxt = cda_pkg::ST_MIN;
        end
      end
      cda_pkg::ST_MIN: begin
        cmd.min_step = 1'b1;
        if (sts.min_done) begin
          state_nxt = cda_pkg::ST_PACK_INIT;
        end
      end
      cda_pkg::ST_PACK_INIT: begin
        cmd.pack_init = 1'b1;
        state_nxt     = cda_pkg::ST_PACK;
      end
      cda_pkg::ST_PACK: begin
        cmd.pack_step = 1'b1;
        if (sts.pack_last) begin
          state_nxt = cda_pkg::ST_DONE;
        end
      end
      cda_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = cda_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cda_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

[hdl/cda_dpath.sv]
// ----------------------------------------------------------------------------
// cda_dpath
// Date-time registers, seconds divider, day/year walker and decimal packer.
// ----------------------------------------------------------------------------
module cda_dpath #(
  parameter int YEAR_WIDTH = cda_pkg::YearWidthDefault
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cda_pkg::cmd_t  cmd,
  output cda_pkg::sts_t  sts,
  input  logic [2:0]     in_operation,
  input  logic [30:0]    in_amount,
  input  logic [13:0]    in_load_year,
  input  logic [6:0]     in_load_month,
  input  logic [6:0]     in_load_day,
  input  logic [6:0]     in_load_hour,
  input  logic [6:0]     in_load_minute,
  input  logic [6:0]     in_load_second,
  output logic [15:0]    out_year,
  output logic [3:0]     out_month,
  output logic [4:0]     out_day,
  output logic [4:0]     out_hour,
  output logic [5:0]     out_minute,
  output logic [5:0]     out_second,
  output logic [49:0]    out_packed_decimal,
  output logic           out_status,
  output logic           out_year_wrapped
);

  localparam logic [YEAR_WIDTH:0] YearMax  = {1'b0, {YEAR_WIDTH{1'b1}}};
  localparam logic [YEAR_WIDTH:0] YearJump = (YEAR_WIDTH + 1)'(cda_pkg::YearsPerCycle);
  localparam logic [YEAR_WIDTH-1:0] YearStep = YEAR_WIDTH'(cda_pkg::YearsPerCycle);
  localparam logic [8:0] MaxMod = 9'(((64'd1 << YEAR_WIDTH) - 64'd1) % 64'd400);
  // 86400 = 128 * 675; ceil(2^35 / 675) is exact for quotients of 25-bit values
  localparam logic [25:0] DayRecip = 26'd50903317;

  // architectural date-time
  logic [YEAR_WIDTH-1:0] year_r, year_nxt;
  logic [8:0]  ymod_r, ymod_nxt;
  logic [3:0]  month_r;
  logic [4:0]  day_r, hour_r;
  logic [5:0]  minute_r, second_r;

  // captured item
  logic [2:0]  op_r;
  logic [30:0] amt_r;
  logic [13:0] ld_year_r;
  logic [6:0]  ld_month_r, ld_day_r, ld_hour_r, ld_minute_r, ld_second_r;

  // working registers
  logic [16:0] tod_r;
  logic [16:0] rem_r;
  logic [31:0] dvd_r;
  logic [50:0] prod_r;
  logic [15:0] quo_r;
  logic [4:0]  cnt_r;
  logic [30:0] n_r, n_nxt;
  logic [8:0]  doy_r, doy_nxt;
  logic [3:0]  mw_r;
  logic [49:0] pk_r;
  logic        rej_r, wrap_r, wrap_nxt;

  logic        leap;
  logic [8:0]  ylen;
  logic        is_add;

  assign leap   = cda_pkg::leap_of(ymod_r);
  assign ylen   = leap ? 9'd366 : 9'd365;
  assign is_add = (op_r == cda_pkg::OP_ADD_SEC) || (op_r == cda_pkg::OP_ADD_DAY);

  // load check: year modulo 400 by conditional subtraction
  logic [13:0] lm0, lm1, lm2, lm3, lm4, lm5;
  logic [8:0]  ld_mod;
  logic [4:0]  ld_mlen;
  logic        ld_ok;

  always_comb begin
    lm0    = (ld_year_r >= 14'd12800) ? ld_year_r - 14'd12800 : ld_year_r;
    lm1    = (lm0 >= 14'd6400) ? lm0 - 14'd6400 : lm0;
    lm2    = (lm1 >= 14'd3200) ? lm1 - 14'd3200 : lm1;
    lm3    = (lm2 >= 14'd1600) ? lm2 - 14'd1600 : lm2;
    lm4    = (lm3 >= 14'd800)  ? lm3 - 14'd800  : lm3;
    lm5    = (lm4 >= 14'd400)  ? lm4 - 14'd400  : lm4;
    ld_mod = lm5[8:0];
    ld_mlen = cda_pkg::month_len(cda_pkg::leap_of(ld_mod), ld_month_r[3:0]);
    ld_ok  = (ld_year_r <= cda_pkg::MaxLoadYear) &&
             (ld_month_r >= 7'd1) && (ld_month_r <= 7'd12) &&
             (ld_day_r >= 7'd1) && (ld_day_r <= {2'd0, ld_mlen}) &&
             (ld_hour_r <= 7'd24) && (ld_minute_r <= 7'd60) && (ld_second_r <= 7'd60);
  end

  // one step of the day walk: a 400-year jump, one year boundary, or the last move within a year
  logic [8:0] ymod_dec;
  logic [8:0] ylen_dec;
  logic       days_done;

  always_comb begin
    if (year_r == '0) begin
      ymod_dec = MaxMod;
    end else if (ymod_r == 9'd0) begin
      ymod_dec = 9'd399;
    end else begin
      ymod_dec = ymod_r - 9'd1;
    end
    ylen_dec = cda_pkg::leap_of(ymod_dec) ? 9'd366 : 9'd365;
  end

  always_comb begin
    year_nxt  = year_r;
    ymod_nxt  = ymod_r;
    doy_nxt   = doy_r;
    n_nxt     = n_r;
    wrap_nxt  = wrap_r;
    days_done = 1'b0;
    if (is_add) begin
      if (n_r >= 31'(cda_pkg::DaysPerCycle) && ({1'b0, year_r} + YearJump) <= YearMax) begin
        year_nxt = year_r + YearStep;
        n_nxt    = n_r - 31'(cda_pkg::DaysPerCycle);
      end else if ((32'(doy_r) + {1'b0, n_r}) < 32'(ylen)) begin
        doy_nxt   = doy_r + n_r[8:0];
        days_done = 1'b1;
      end else begin
        n_nxt    = n_r - (31'(ylen) - 31'(doy_r));
        doy_nxt  = 9'd0;
        year_nxt = year_r + YEAR_WIDTH'(1);
        if (year_r == YearMax[YEAR_WIDTH-1:0]) begin
          wrap_nxt = 1'b1;
          ymod_nxt = 9'd0;
        end else begin
          ymod_nxt = (ymod_r == 9'd399) ? 9'd0 : ymod_r + 9'd1;
        end
      end
    end else begin
      if (n_r >= 31'(cda_pkg::DaysPerCycle) && year_r >= YearStep) begin
        year_nxt = year_r - YearStep;
        n_nxt    = n_r - 31'(cda_pkg::DaysPerCycle);
      end else if (n_r <= 31'(doy_r)) begin
        doy_nxt   = doy_r - n_r[8:0];
        days_done = 1'b1;
      end else begin
        n_nxt    = n_r - (31'(doy_r) + 31'd1);
        year_nxt = year_r - YEAR_WIDTH'(1);
        ymod_nxt = ymod_dec;
        doy_nxt  = ylen_dec - 9'd1;
        if (year_r == '0) begin
          wrap_nxt = 1'b1;
        end
      end
    end
  end

  // month walk and packer helpers
  logic [4:0]  mlen_walk, mlen_cur;
  logic        month_adv;
  logic [6:0]  pk_field;

  assign mlen_walk = cda_pkg::month_len(leap, mw_r);
  assign mlen_cur  = cda_pkg::month_len(leap, month_r);
  assign month_adv = (month_r < 4'd12) && (doy_r >= {4'd0, mlen_cur});

  always_comb begin
    case (cnt_r[2:0])
      3'd0:    pk_field = {3'd0, month_r};
      3'd1:    pk_field = {2'd0, day_r};
      3'd2:    pk_field = {2'd0, hour_r};
      3'd3:    pk_field = {1'b0, minute_r};
      default: pk_field = {1'b0, second_r};
    endcase
  end

  always_comb begin
    sts.op         = op_r;
    sts.div_last   = (cnt_r == 5'd1);
    sts.doy_done   = (mw_r >= month_r);
    sts.days_done  = days_done;
    sts.month_done = !month_adv;
    sts.hour_done  = tod_r < 17'(cda_pkg::SecsPerHour);
    sts.min_done   = tod_r < 17'(cda_pkg::SecsPerMin);
    sts.pack_last  = (cnt_r == 5'd4);
  end

  // architectural state: reset to 0000-01-01 00:00:00
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r   <= '0;
      ymod_r   <= 9'd0;
      month_r  <= 4'd1;
      day_r    <= 5'd1;
      hour_r   <= 5'd0;
      minute_r <= 6'd0;
      second_r <= 6'd0;
    end else begin
      if (cmd.load && ld_ok) begin
        year_r   <= YEAR_WIDTH'(ld_year_r);
        ymod_r   <= ld_mod;
        month_r  <= ld_month_r[3:0];
        day_r    <= ld_day_r[4:0];
        hour_r   <= (ld_hour_r == 7'd24) ? 5'd0 : ld_hour_r[4:0];
        minute_r <= (ld_minute_r == 7'd60) ? 6'd0 : ld_minute_r[5:0];
        second_r <= (ld_second_r == 7'd60) ? 6'd0 : ld_second_r[5:0];
      end
      if (cmd.days_step) begin
        year_r <= year_nxt;
        ymod_r <= ymod_nxt;
        if (days_done) begin
          month_r <= 4'd1;
        end
      end
      if (cmd.month_step) begin
        if (month_adv) begin
          month_r <= month_r + 4'd1;
        end else begin
          day_r    <= doy_r[4:0] + 5'd1;
          hour_r   <= 5'd0;
          minute_r <= 6'd0;
        end
      end
      if (cmd.hour_step && !sts.hour_done) begin
        hour_r <= hour_r + 5'd1;
      end
      if (cmd.min_step) begin
        if (sts.min_done) begin
          second_r <= tod_r[5:0];
        end else begin
          minute_r <= minute_r + 6'd1;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r        <= in_operation;
      amt_r       <= in_amount;
      ld_year_r   <= in_load_year;
      ld_month_r  <= in_load_month;
      ld_day_r    <= in_load_day;
      ld_hour_r   <= in_load_hour;
      ld_minute_r <= in_load_minute;
      ld_second_r <= in_load_second;
      rej_r       <= 1'b0;
      wrap_r      <= 1'b0;
    end
    if (cmd.load) begin
      rej_r <= !ld_ok;
    end
    if (cmd.tod_init) begin
      tod_r <= 17'({12'd0, hour_r} * 17'(cda_pkg::SecsPerHour)) +
               17'({11'd0, minute_r} * 17'(cda_pkg::SecsPerMin)) + {11'd0, second_r};
      n_r   <= amt_r;
      doy_r <= {4'd0, day_r} - 9'd1;
      mw_r  <= 4'd1;
    end
    if (cmd.div_init) begin
      dvd_r <= (op_r == cda_pkg::OP_ADD_SEC) ? 32'(tod_r) + {1'b0, amt_r} : {1'b0, amt_r};
      cnt_r <= 5'd0;
    end
    if (cmd.div_step) begin
      // first step forms the reciprocal product; second takes the quotient and the remainder
      if (cnt_r == 5'd0) begin
        prod_r <= 51'(dvd_r[31:7]) * 51'(DayRecip);
      end else begin
        quo_r <= prod_r[50:35];
        rem_r <= 17'(dvd_r - 32'(prod_r[50:35]) * 32'(cda_pkg::SecsPerDay));
      end
      cnt_r <= cnt_r + 5'd1;
    end
    if (cmd.div_fix) begin
      if (op_r == cda_pkg::OP_ADD_SEC) begin
        tod_r <= rem_r;
        n_r   <= {15'd0, quo_r};
      end else if (rem_r > tod_r) begin
        tod_r <= 17'({1'b0, tod_r} + {1'b0, cda_pkg::SecsPerDay} - {1'b0, rem_r});
        n_r   <= {15'd0, quo_r} + 31'd1;
      end else begin
        tod_r <= tod_r - rem_r;
        n_r   <= {15'd0, quo_r};
      end
    end
    if (cmd.doy_step && !sts.doy_done) begin
      doy_r <= doy_r + {4'd0, mlen_walk};
      mw_r  <= mw_r + 4'd1;
    end
    if (cmd.days_step) begin
      doy_r  <= doy_nxt;
      n_r    <= n_nxt;
      wrap_r <= wrap_nxt;
    end
    if (cmd.month_step && month_adv) begin
      doy_r <= doy_r - {4'd0, mlen_cur};
    end
    if (cmd.hour_step && !sts.hour_done) begin
      tod_r <= tod_r - 17'(cda_pkg::SecsPerHour);
    end
    if (cmd.min_step && !sts.min_done) begin
      tod_r <= tod_r - 17'(cda_pkg::SecsPerMin);
    end
    if (cmd.pack_init) begin
      pk_r  <= 50'(year_r);
      cnt_r <= 5'd0;
    end
    if (cmd.pack_step) begin
      // times 100 as 64 + 32 + 4
      pk_r  <= (pk_r << 6) + (pk_r << 5) + (pk_r << 2) + 50'(pk_field);
      cnt_r <= cnt_r + 5'd1;
    end
    if (cmd.out_load) begin
      out_year           <= 16'(year_r);
      out_month          <= month_r;
      out_day            <= day_r;
      out_hour           <= hour_r;
      out_minute         <= minute_r;
      out_second         <= second_r;
      out_packed_decimal <= pk_r;
      out_status         <= rej_r;
      out_year_wrapped   <= wrap_r;
    end
  end

endmodule

[hdl/calendar_datetime_adder.sv]
// Phases to out_valid: a load checks and writes valid fields; an unused code changes nothing;
//   day add/sub walks day of year, years, months, hours and minutes; each then packs.
// Seconds add/sub first divides by 86400 through a reciprocal multiply.
// Years step one per cycle, or 400 at a time while the year range allows.
// Throughput: one item in flight; the next item is taken while a result waits in the output.
// Reset (synchronous, rst_n low) sets the date-time to year 0, Jan 1, 00:00:00.
// ----------------------------------------------------------------------------
// calendar_datetime_adder
// Gregorian date-time register with load and second/day add and subtract.
// ----------------------------------------------------------------------------
module calendar_datetime_adder #(
  parameter int YEAR_WIDTH = cda_pkg::YearWidthDefault
) (
  input  logic  clk,
  input  logic  rst_n,
  cda_in_if.sink    in_ch,
  cda_out_if.source out_ch
);

  cda_pkg::cmd_t cmd;
  cda_pkg::sts_t sts;

  // Sequencer: accepts a beat in idle, steps the datapath through its phases,
  // then parks the result in the output register once that register is free.
  cda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: holds the date-time, the seconds divider, the day walker and the
  // packed decimal builder; the output register lives here too.
  cda_dpath #(
    .YEAR_WIDTH (YEAR_WIDTH)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_operation       (in_ch.operation),
    .in_amount          (in_ch.amount),
    .in_load_year       (in_ch.load_year),
    .in_load_month      (in_ch.load_month),
    .in_load_day        (in_ch.load_day),
    .in_load_hour       (in_ch.load_hour),
    .in_load_minute     (in_ch.load_minute),
    .in_load_second     (in_ch.load_second),
    .out_year           (out_ch.year),
    .out_month          (out_ch.month),
    .out_day            (out_ch.day),
    .out_hour           (out_ch.hour),
    .out_minute         (out_ch.minute),
    .out_second         (out_ch.second),
    .out_packed_decimal (out_ch.packed_decimal),
    .out_status         (out_ch.status),
    .out_year_wrapped   (out_ch.year_wrapped)
  );

endmodule

[hdl/cda_checker.sv]
// ----------------------------------------------------------------------------
// cda_checker
// Port-level checks for the calendar date-time adder.
// ----------------------------------------------------------------------------
module cda_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  month,
  input logic [4:0]  day,
  input logic [4:0]  hour,
  input logic [5:0]  minute,
  input logic [5:0]  second,
  input logic [49:0] packed_decimal,
  input logic        status,
  input logic        year_wrapped
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(packed_decimal))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while an item is in work");

  a_reject_nowrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status |-> !year_wrapped)
    else $error("rejected load flagged a year wrap");

  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> month >= 4'd1 && month <= 4'd12 && day >= 5'd1 &&
                  hour < 5'd24 && minute < 6'd60 && second < 6'd60)
    else $error("date-time field out of range");

endmodule

bind calendar_datetime_adder cda_checker u_cda_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .month          (out_ch.month),
  .day            (out_ch.day),
  .hour           (out_ch.hour),
  .minute         (out_ch.minute),
  .second         (out_ch.second),
  .packed_decimal (out_ch.packed_decimal),
  .status         (out_ch.status),
  .year_wrapped   (out_ch.year_wrapped)
);
